// ===== design/mbtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtp_pkg: shared types and constants of the three-pixel word packer
// Holds the job record that travels from the byte front end to the word
// sequencer, and the sizes of the job queue between them.
// ----------------------------------------------------------------------------
package mbtp_pkg;

  // Number of jobs the queue between front and back can hold.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_ORDER  = 1'b0,
    CFG_BYTE_ORDER = 1'b1
  } cfg_idx_e;

  // One classified input byte: up to four three-pixel groups, earliest
  // group in the top bits, the number of words to emit (2 to 4) and the
  // flag of a final byte.
  typedef struct packed {
    logic [11:0] groups;
    logic [2:0]  count;
    logic        fin;
  } job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic valid;
    job_t head;
  } q_head_t;

endpackage

// ===== design/mono_bitmap_three_pixel_word_packer.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_three_pixel_word_packer: 1 bpp bitmap to display word packer
// Cuts a stream of one-bit pixels into groups of three and emits one
// 16-bit display word per group as two bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Beat content
//   -------  ---------  ----------------------  ------------------------------
//   in       sink       in_valid_i/in_stall_o   bitmap_byte_i, final_byte_i
//   out      source     out_valid_o/out_stall_i first/second_byte, run_last,
//                                               buffer_end
//   cfg      sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// Each input beat produces two to four output beats, one per cycle while
// the output is not stalled; the word sequencer that emits them is what
// sets the sustained rate.
// The words of a byte pass through the job queue and then the output
// register. Reset clears the pixel carry, the queue and the output
// valid. A stalled output only holds the sequencer; the front end keeps
// taking bytes until the two-entry job queue is full.
module mono_bitmap_three_pixel_word_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [mbtp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic                         cfg_data_i,
  // Input byte channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   bitmap_byte_i,
  input  logic                         final_byte_i,
  // Output word channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   first_byte_o,
  output logic [7:0]                   second_byte_o,
  output logic                         run_last_o,
  output logic                         buffer_end_o
);

  logic              bit_order_q;
  logic              byte_order_q;
  logic              q_full;
  logic              push;
  logic              pop;
  mbtp_pkg::job_t    job;
  mbtp_pkg::q_head_t head;

  // Configuration registers. The user must write only while the block is
  // idle; the block does not enforce it. The datapath reads them unshadowed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_order_q  <= 1'b0;
      byte_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mbtp_pkg::cfg_idx_e'(cfg_index_i))
        mbtp_pkg::CFG_BIT_ORDER:  bit_order_q  <= cfg_data_i;
        mbtp_pkg::CFG_BYTE_ORDER: byte_order_q <= cfg_data_i;
        default:                  bit_order_q  <= bit_order_q;
      endcase
    end
  end

  // A byte is taken whenever the queue has room; the carry update happens
  // at that same edge, so the front end waits only while the queue is full.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  mbtp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bit_order_i   (bit_order_q),
    .push_i        (push),
    .bitmap_byte_i (bitmap_byte_i),
    .final_byte_i  (final_byte_i),
    .job_o         (job)
  );

  mbtp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // The sequencer pops a job when its last word enters the output register.
  mbtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_order_i  (byte_order_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .run_last_o    (run_last_o),
    .buffer_end_o  (buffer_end_o)
  );

`ifndef SYNTHESIS
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(first_byte_o)
                                      && $stable(second_byte_o)))
    else $error("top: stalled output word changed");
`endif

endmodule

// ===== design/mbtp_front.sv =====
// ----------------------------------------------------------------------------
// mbtp_front: byte front end
// Orders the pixels of each byte, joins them with the carried pixels, cuts
// the stream into three-pixel groups and keeps the leftover pixels.
// ----------------------------------------------------------------------------
module mbtp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                bit_order_i,
  input  logic                push_i,
  input  logic [7:0]          bitmap_byte_i,
  input  logic                final_byte_i,
  output mbtp_pkg::job_t      job_o
);

  logic [1:0] carry_bits_q, carry_bits_d;
  logic [1:0] carry_count_q, carry_count_d;
  logic [7:0] pix;
  logic [9:0] stream;

  // Pixel order: bit 7 first, or bit 0 first when the byte is reversed.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pix[i] = bit_order_i ? bitmap_byte_i[7-i] : bitmap_byte_i[i];
    end
  end

  // The stream is left-aligned in ten bits, earliest pixel at bit 9, with
  // zero pixels after its end so that a partial group is already padded.
  always_comb begin
    stream        = {pix, 2'b00};
    job_o.count   = final_byte_i ? 3'd3 : 3'd2;
    carry_bits_d  = pix[1:0];
    carry_count_d = 2'd2;
    unique case (carry_count_q)
      2'd1: begin
        stream        = {carry_bits_q[0], pix, 1'b0};
        job_o.count   = 3'd3;
        carry_bits_d  = 2'b00;
        carry_count_d = 2'd0;
      end
      2'd2: begin
        stream        = {carry_bits_q, pix};
        job_o.count   = final_byte_i ? 3'd4 : 3'd3;
        carry_bits_d  = {1'b0, pix[0]};
        carry_count_d = 2'd1;
      end
      default: begin
        stream        = {pix, 2'b00};
        job_o.count   = final_byte_i ? 3'd3 : 3'd2;
        carry_bits_d  = pix[1:0];
        carry_count_d = 2'd2;
      end
    endcase
    if (final_byte_i) begin
      carry_bits_d  = 2'b00;
      carry_count_d = 2'd0;
    end
    job_o.groups = {stream, 2'b00};
    job_o.fin    = final_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_bits_q  <= 2'b00;
      carry_count_q <= 2'd0;
    end else if (push_i) begin
      carry_bits_q  <= carry_bits_d;
      carry_count_q <= carry_count_d;
    end
  end

`ifndef SYNTHESIS
  a_carry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carry_count_q != 2'd3)
    else $error("front: carry count out of range");
`endif

endmodule

// ===== design/mbtp_queue.sv =====
// ----------------------------------------------------------------------------
// mbtp_queue: job queue
// A small register queue that lets the front end keep taking bytes while
// the back end is still emitting words of earlier ones.
// ----------------------------------------------------------------------------
module mbtp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbtp_pkg::job_t    job_i,
  input  logic              pop_i,
  output logic              full_o,
  output mbtp_pkg::q_head_t head_o
);

  localparam int unsigned PtrW = mbtp_pkg::QPtrW;
  localparam int unsigned CntW = mbtp_pkg::QCntW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(mbtp_pkg::QDepth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(mbtp_pkg::QDepth);

  mbtp_pkg::job_t  mem_q [mbtp_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == Full);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.head  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue: push into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("queue: pop from an empty queue");
`endif

endmodule

// ===== design/mbtp_back.sv =====
// ----------------------------------------------------------------------------
// mbtp_back: word sequencer
// Walks the groups of the job at the head of the queue, one display word a
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module mbtp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_order_i,
  input  mbtp_pkg::q_head_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        first_byte_o,
  output logic [7:0]        second_byte_o,
  output logic              run_last_o,
  output logic              buffer_end_o
);

  localparam logic [15:0] Pix0Mask = 16'h00F8;
  localparam logic [15:0] Pix1Mask = 16'hC007;
  localparam logic [15:0] Pix2Mask = 16'h1F00;

  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q;
  logic [7:0]  first_q, second_q;
  logic        run_last_q, buffer_end_q;
  logic        load;
  logic        last;
  logic [2:0]  grp;
  logic [15:0] word;

  assign load = head_i.valid && (!out_valid_q || !out_stall_i);
  assign last = ({1'b0, idx_q} == (head_i.head.count - 3'd1));
  assign pop_o = load && last;

  always_comb begin
    unique case (idx_q)
      2'd0:    grp = head_i.head.groups[11:9];
      2'd1:    grp = head_i.head.groups[8:6];
      2'd2:    grp = head_i.head.groups[5:3];
      default: grp = head_i.head.groups[2:0];
    endcase
    word = ({16{grp[2]}} & Pix0Mask) | ({16{grp[1]}} & Pix1Mask)
         | ({16{grp[0]}} & Pix2Mask);
    idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      first_q      <= byte_order_i ? word[15:8] : word[7:0];
      second_q     <= byte_order_i ? word[7:0] : word[15:8];
      run_last_q   <= last;
      buffer_end_q <= last && head_i.head.fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_byte_o  = first_q;
  assign second_byte_o = second_q;
  assign run_last_o    = run_last_q;
  assign buffer_end_o  = buffer_end_q;

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> ({1'b0, idx_q} < head_i.head.count))
    else $error("back: word index past the end of the job");
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && buffer_end_q) |-> run_last_q)
    else $error("back: buffer end on a word that is not the last of its byte");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the three-pixel display word packer
// Drives bitmap bytes into the packer under every bit and byte order, with
// and without gaps on either channel. A behavioral copy of the packing rules
// predicts each display word, and every output beat is checked against it.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Masks that each pixel of a group lights up in the display word.
  localparam logic [15:0] FirstPixMask  = 16'h00F8;
  localparam logic [15:0] SecondPixMask = 16'hC007;
  localparam logic [15:0] ThirdPixMask  = 16'h1F00;

  // A generous ceiling on the whole run. The slowest legal run is a few
  // hundred bytes, four words each, with long output stalls, which is well
  // under a tenth of this.
  localparam int unsigned RunLimitNs = 2_000_000;

  // Cycles to linger after the last owed word, as a margin.
  localparam int unsigned TailCycles = 8;

  // One output beat: a display word split into bytes plus its two flags.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       run_last;
    logic       buffer_end;
  } word_beat_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  mbtp_pkg::cfg_idx_e   cfg_index_i   = mbtp_pkg::CFG_BIT_ORDER;
  logic                 cfg_data_i    = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           bitmap_byte_i = 8'h00;
  logic                 final_byte_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [7:0]           first_byte_o;
  logic [7:0]           second_byte_o;
  logic                 run_last_o;
  logic                 buffer_end_o;

  mono_bitmap_three_pixel_word_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .bitmap_byte_i (bitmap_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .first_byte_o  (first_byte_o),
    .second_byte_o (second_byte_o),
    .run_last_o    (run_last_o),
    .buffer_end_o  (buffer_end_o)
  );

  // Shadow of the packer: its two order registers and the pixel carry.
  logic       bit_order_q   = 1'b0;
  logic       byte_order_q  = 1'b0;
  logic [1:0] carry_bits_q  = 2'b00;
  int         carry_count_q = 0;

  // Display words still owed by the packer, oldest at the front.
  word_beat_t pending_words[$];

  // Idle rates of the two channels in percent, changed from phase to phase.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  int unsigned err_count     = 0;
  int unsigned bytes_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned flush_bytes   = 0;

  word_beat_t got_beat;
  word_beat_t want_beat;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Build the beat for one three-pixel group. The earliest pixel sits in
  // bit 2 of the group.
  function automatic word_beat_t group_beat(input logic [2:0] grp);
    logic [15:0] word;
    word_beat_t  beat;
    word = 16'h0000;
    if (grp[2]) word |= FirstPixMask;
    if (grp[1]) word |= SecondPixMask;
    if (grp[0]) word |= ThirdPixMask;
    beat.first      = byte_order_q ? word[15:8] : word[7:0];
    beat.second     = byte_order_q ? word[7:0]  : word[15:8];
    beat.run_last   = 1'b0;
    beat.buffer_end = 1'b0;
    return beat;
  endfunction

  // Work out the words that one accepted byte causes and queue them. The
  // carried pixels go in front of the new byte, and groups are taken from
  // the top of the stream down. A flagged byte pads any partial group with
  // zero pixels and empties the carry.
  task automatic predict_words(input logic [7:0] pix_byte, input logic fin);
    logic [7:0]  pix;
    logic [9:0]  stream;
    logic [2:0]  grp;
    int          nbits;
    int          nwords;
    word_beat_t  beats[4];
    pix = pix_byte;
    if (bit_order_q) begin
      for (int i = 0; i < 8; i++) pix[i] = pix_byte[7-i];
    end
    stream = {carry_bits_q, pix};
    nbits  = carry_count_q + 8;
    nwords = 0;
    while (nbits >= 3) begin
      grp = 3'(stream >> (nbits - 3));
      beats[nwords] = group_beat(grp);
      nwords++;
      nbits -= 3;
    end
    stream &= (10'd1 << nbits) - 10'd1;
    if (fin) begin
      // Leftover pixels open one padded word; a clean split needs none.
      if (nbits > 0) begin
        grp = 3'(stream << (3 - nbits));
        beats[nwords] = group_beat(grp);
        nwords++;
      end
      carry_bits_q  = 2'b00;
      carry_count_q = 0;
      beats[nwords-1].buffer_end = 1'b1;
    end else begin
      carry_bits_q  = stream[1:0];
      carry_count_q = nbits;
    end
    beats[nwords-1].run_last = 1'b1;
    for (int i = 0; i < nwords; i++) pending_words.push_back(beats[i]);
  endtask

  // Offer one byte, with random gaps in front of it, and hold it until the
  // packer takes it. Returns at the edge where the beat was accepted.
  task automatic send_byte(input logic [7:0] pix_byte, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    bitmap_byte_i <= pix_byte;
    final_byte_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_words(pix_byte, fin);
    bytes_sent++;
    if (fin) flush_bytes++;
  endtask

  // Stop offering bytes and wait for every owed word. Every byte causes at
  // least two words, so an empty queue also means the packer is idle; the
  // extra cycles are only margin.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Write one order register. Called only while the packer is idle; the
  // caller drops the write enable after its last write.
  task automatic write_cfg(input mbtp_pkg::cfg_idx_e idx, input logic value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == mbtp_pkg::CFG_BIT_ORDER) bit_order_q = value;
    else byte_order_q = value;
  endtask

  task automatic set_orders(input logic bit_ord, input logic byte_ord);
    wait_drained();
    write_cfg(mbtp_pkg::CFG_BIT_ORDER, bit_ord);
    write_cfg(mbtp_pkg::CFG_BYTE_ORDER, byte_ord);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly uniform bytes, with the all-dark, all-lit and single-pixel
  // patterns mixed in so that edge groups show up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Directed walk through the carry states under the reset orders. It
  // covers a flagged byte that leaves two pixels (padded word), one pixel
  // (padded word) and none (the last full word takes the end flag), as well
  // as all-dark and all-lit bytes.
  task automatic test_directed_groups();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Each register at both of its values, with bytes whose lit pixel sits
  // at one end so that a wrong bit order or byte order is visible at once.
  task automatic test_order_extremes();
    logic [1:0] combos[3] = '{2'b10, 2'b01, 2'b11};
    foreach (combos[i]) begin
      set_orders(combos[i][1], combos[i][0]);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b1);
    end
  endtask

  // The sender stops in the middle of a buffer, where pixels may still be
  // carried, and waits for every owed word before going on with the same buffer.
  task automatic test_pause_mid_buffer();
    send_byte(pick_byte(), 1'b0);
    send_byte(pick_byte(), 1'b0);
    wait_drained();
    send_byte(pick_byte(), 1'b0);
    send_byte(pick_byte(), 1'b1);
  endtask

  // Random buffers of one to ten bytes, the last one flagged. A phase may
  // end inside a buffer, so the carry crosses the following order change.
  // A few bytes carry the flag at random as noise.
  task automatic test_random_buffers(input int unsigned nbytes,
                                     input int unsigned src_pct,
                                     input int unsigned sink_pct);
    int unsigned left_in_buf;
    logic        fin;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    left_in_buf    = 0;
    repeat (nbytes) begin
      if (left_in_buf == 0) left_in_buf = $urandom_range(10, 1);
      left_in_buf--;
      fin = (left_in_buf == 0) || ($urandom_range(99) < 4);
      if (fin) left_in_buf = 0;
      send_byte(pick_byte(), fin);
    end
  endtask

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %02h, actual %02h",
               $realtime, fname, want, got);
      err_count++;
    end
  endtask

  // Every accepted output beat is compared with the oldest owed word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat = '{first_byte_o, second_byte_o, run_last_o, buffer_end_o};
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %02h %02h %b %b",
                 $realtime, got_beat.first, got_beat.second,
                 got_beat.run_last, got_beat.buffer_end);
        err_count++;
      end else begin
        want_beat = pending_words.pop_front();
        check_field("first_byte", want_beat.first, got_beat.first);
        check_field("second_byte", want_beat.second, got_beat.second);
        check_field("run_last", 8'(want_beat.run_last), 8'(got_beat.run_last));
        check_field("buffer_end", 8'(want_beat.buffer_end),
                    8'(got_beat.buffer_end));
        words_checked++;
      end
    end
  end

  initial begin
    #(RunLimitNs * 1ns);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // Reset once, then run the phases in turn. Orders change only while
    // nothing is owed.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_groups();
    test_order_extremes();

    // Random phases: back to back, idle sender, stalling receiver, both.
    set_orders(1'b1, 1'b1);
    test_random_buffers(60, 0, 0);
    test_pause_mid_buffer();
    set_orders(1'b0, 1'b1);
    test_random_buffers(60, 56, 0);
    set_orders(1'b1, 1'b0);
    test_random_buffers(60, 0, 56);
    set_orders(1'b0, 1'b0);
    test_random_buffers(60, 26, 26);

    wait_drained();

    $display("Covered %0d bitmap bytes (%0d flagged as buffer end), %0d words checked,",
             bytes_sent, flush_bytes, words_checked);
    $display("all four bit/byte order settings, idle and stalled channels.");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbtp_pkg.sv
design/mbtp_front.sv
design/mbtp_queue.sv
design/mbtp_back.sv
design/mono_bitmap_three_pixel_word_packer.sv
verif/tb.sv
